// ===== src/rar_pkg.sv =====
// rar_pkg: shared types and constants for the rational arithmetic block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;
  localparam int unsigned OperandWidthDef = 32;
  localparam int unsigned ProdW = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [ProdW-1:0] num;
    logic signed [ProdW-1:0] den;
    status_e                 status;
  } job_t;
endpackage
`default_nettype wire

// ===== src/rational_arith_reduce_top.sv =====
// rational_arith_reduce_top: exact fraction add/sub/mul/div with GCD reduction.
// Depends on rar_pkg, rar_front, rar_queue, rar_back.
// Usage:
//  s_axis beat: tuser = req_type, tdata = {b_den, b_num, a_den, a_num} (a_num low).
//  m_axis beat: tuser = status, tdata = {res_den, res_num} (res_num low).
//  Every request gives exactly one result beat.
//  Front makes up to two multiplier passes and, for add/sub, a sum check per request,
//  then hands the job through a two-entry queue to the back end.
//  Back end: one shared bit-serial remainder unit; each Euclid step is a 64-bit
//  quotient pass plus one check, and two exact divisions follow.
//  Error results skip the Euclid steps and the divisions.
//  Throughput is one beat per back-end job; the back end sets the pace.
//  The front keeps accepting while the back works, until the queue fills.
//  A stalled m_axis holds its beat; the back end waits, the queue backs up
//  and s_axis_tready falls.
//  Reset clears all control state; no item is in flight afterwards.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce_top #(
  parameter int unsigned OPERAND_WIDTH = rar_pkg::OperandWidthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
  input  wire logic [1:0]   s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,  // res_num, res_den
  output logic [1:0]        m_axis_tuser   // status
);
  import rar_pkg::*;

  job_t f_job, q_job, b_res;
  logic f_valid, f_ready, q_valid, q_ready;

  rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_type_i (s_axis_tuser),
    .a_num_i    (s_axis_tdata[31:0]),
    .a_den_i    (s_axis_tdata[63:32]),
    .b_num_i    (s_axis_tdata[95:64]),
    .b_den_i    (s_axis_tdata[127:96]),
    .job_valid_o(f_valid),
    .job_ready_i(f_ready),
    .job_o      (f_job)
  );

  rar_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  rar_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(b_res)
  );

  assign m_axis_tdata = {b_res.den, b_res.num};
  assign m_axis_tuser = b_res.status;
endmodule
`default_nettype wire

// ===== src/rar_front.sv =====
// rar_front: accepts requests, checks denominators and divisors, cross-multiplies,
// checks add/sub sums for overflow. Depends on rar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rar_front #(
  parameter int unsigned OPERAND_WIDTH = rar_pkg::OperandWidthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   req_type_i,
  input  wire logic [31:0]  a_num_i,
  input  wire logic [31:0]  a_den_i,
  input  wire logic [31:0]  b_num_i,
  input  wire logic [31:0]  b_den_i,
  output logic              job_valid_o,
  input  wire logic         job_ready_i,
  output rar_pkg::job_t     job_o
);
  import rar_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL1, S_MUL2, S_SUM} state_e;

  state_e state_q;
  op_e op_q;
  logic signed [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [ProdW-1:0] p1_q, p2_q;
  logic signed [OPERAND_WIDTH-1:0] ma1, mb1, ma2, mb2;
  logic signed [ProdW-1:0] m1, m2, p2n, sum;
  logic ovf;
  job_t job_q;
  logic job_valid_q;

  assign in_ready_o  = (state_q == S_IDLE) && !job_valid_q;
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  // Stage 1: numerator products; stage 2: denominator product.
  always_comb begin
    ma1 = an_q; mb1 = bd_q; ma2 = bn_q; mb2 = ad_q;
    if (state_q == S_MUL2) begin
      ma1 = ad_q;
      mb1 = (op_q == OP_DIV) ? bn_q : bd_q;
    end else if (op_q == OP_MUL) begin
      mb1 = bn_q;
    end
  end
  assign m1  = ProdW'(ma1) * ProdW'(mb1);
  assign m2  = ProdW'(ma2) * ProdW'(mb2);
  assign p2n = (op_q == OP_SUB) ? -p2_q : p2_q;
  assign sum = p1_q + p2n;
  assign ovf = (p1_q[ProdW-1] == p2n[ProdW-1]) && (sum[ProdW-1] != p1_q[ProdW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_valid_q <= 1'b0;
    end else begin
      if (job_valid_q && job_ready_i) job_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            op_q <= op_e'(req_type_i);
            an_q <= a_num_i[OPERAND_WIDTH-1:0];
            ad_q <= a_den_i[OPERAND_WIDTH-1:0];
            bn_q <= b_num_i[OPERAND_WIDTH-1:0];
            bd_q <= b_den_i[OPERAND_WIDTH-1:0];
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1_q <= m1;
          p2_q <= m2;
          if (ad_q == '0 || bd_q == '0) begin
            job_q <= '{num: '0, den: '0, status: ST_ZERO_DEN};
            job_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else if (op_q == OP_DIV && bn_q == '0) begin
            job_q <= '{num: '0, den: '0, status: ST_DIV_ZERO};
            job_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MUL2;
          end
        end
        S_MUL2: begin
          job_q.den <= m1;
          job_q.num <= p1_q;
          job_q.status <= ST_OK;
          if (op_q == OP_ADD || op_q == OP_SUB) begin
            state_q <= S_SUM;
          end else begin
            job_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_SUM: begin
          if (ovf) begin
            job_q <= '{num: '0, den: '0, status: ST_OVERFLOW};
          end else begin
            job_q.num <= sum;
          end
          job_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/rar_queue.sv =====
// rar_queue: two-entry queue of jobs between front and back.
// Depends on rar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rar_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_valid_i,
  output logic          wr_ready_o,
  input  rar_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  wire logic     rd_ready_i,
  output rar_pkg::job_t rd_data_o
);
  import rar_pkg::*;

  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== src/rar_back.sv =====
// rar_back: GCD by shared restoring remainder unit, then exact division.
// Depends on rar_pkg. One quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rar_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_valid_i,
  output logic          job_ready_o,
  input  rar_pkg::job_t job_i,
  output logic          res_valid_o,
  input  wire logic     res_ready_i,
  output rar_pkg::job_t res_o
);
  import rar_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW);

  typedef enum logic [2:0] {
    S_IDLE, S_GCD_CHK, S_GCD_DIV, S_QN, S_QD, S_OUT
  } state_e;

  state_e state_q;
  logic signed [ProdW-1:0] num_q, den_q;
  logic [ProdW-1:0] x_q, y_q;       // gcd operands
  logic [ProdW-1:0] rem_q, quo_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  status_e st_q;
  job_t res_q;
  logic res_valid_q;
  logic [ProdW:0] rtry;
  logic [ProdW-1:0] mag_n, mag_d;

  assign mag_n = num_q[ProdW-1] ? -num_q : num_q;
  assign mag_d = den_q[ProdW-1] ? -den_q : den_q;
  assign rtry  = {rem_q, quo_q[ProdW-1]} - {1'b0, dvs_q};
  assign job_ready_o = state_q == S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            num_q <= job_i.num;
            den_q <= job_i.den;
            st_q  <= job_i.status;
            state_q <= (job_i.status == ST_OK) ? S_GCD_CHK : S_OUT;
            x_q <= '0;
            y_q <= '0;
          end
        end
        S_GCD_CHK: begin
          if (x_q == '0 && y_q == '0) begin
            x_q <= mag_n;
            y_q <= mag_d;
          end else if (y_q == '0) begin
            if (x_q == '0) state_q <= S_OUT;
            else begin
              rem_q <= '0; quo_q <= mag_n; dvs_q <= x_q;
              cnt_q <= '0; state_q <= S_QN;
            end
          end else begin
            rem_q <= '0; quo_q <= x_q; dvs_q <= y_q;
            cnt_q <= '0; state_q <= S_GCD_DIV;
          end
        end
        S_GCD_DIV, S_QN, S_QD: begin
          if (rtry[ProdW]) begin
            rem_q <= {rem_q[ProdW-2:0], quo_q[ProdW-1]};
            quo_q <= {quo_q[ProdW-2:0], 1'b0};
          end else begin
            rem_q <= rtry[ProdW-1:0];
            quo_q <= {quo_q[ProdW-2:0], 1'b1};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(ProdW - 1)) begin
            unique case (state_q)
              S_GCD_DIV: begin
                x_q <= y_q;
                y_q <= rtry[ProdW] ? {rem_q[ProdW-2:0], quo_q[ProdW-1]}
                                   : rtry[ProdW-1:0];
                state_q <= S_GCD_CHK;
              end
              S_QN: begin
                num_q <= num_q[ProdW-1]
                  ? -{quo_q[ProdW-2:0], ~rtry[ProdW]}
                  : {quo_q[ProdW-2:0], ~rtry[ProdW]};
                rem_q <= '0; quo_q <= mag_d; cnt_q <= '0;
                state_q <= S_QD;
              end
              default: begin
                den_q <= den_q[ProdW-1]
                  ? -{quo_q[ProdW-2:0], ~rtry[ProdW]}
                  : {quo_q[ProdW-2:0], ~rtry[ProdW]};
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!res_valid_q) begin
            res_q <= '{num: num_q, den: den_q, status: st_q};
            res_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/rational_arith_reduce_top_tb.sv =====
// rational_arith_reduce_top_tb: checks the fraction add/sub/mul/div block with GCD reduction.
// Holds a scoreboard class that predicts every result; tasks drive the stream.
// Depends on rar_pkg and rational_arith_reduce_top.
`timescale 1ns / 1ps
module rational_arith_reduce_top_tb;
  import rar_pkg::*;

  localparam longint unsigned CycleLimit = 30_000_000;
  localparam int RandItems = 1430;

  typedef struct {
    bit [63:0] num;
    bit [63:0] den;
    status_e   st;
  } frac_res_t;

  class frac_scoreboard;
    frac_res_t pending_q[$];
    int errors;
    int checked;
    int op_cnt[4];
    int st_cnt[4];

    function automatic bit [63:0] magn(longint x);
      return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    function automatic bit [63:0] euclid(bit [63:0] a, bit [63:0] b);
      bit [63:0] t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function automatic bit [63:0] div_by(longint x, bit [63:0] g);
      bit [63:0] q;
      q = magn(x) / g;
      return x < 0 ? 64'd0 - q : q;
    endfunction

    function automatic void note_request(op_e op, bit [31:0] an_b, bit [31:0] ad_b,
                                         bit [31:0] bn_b, bit [31:0] bd_b);
      longint an, ad, bn, bd, nu, de, p1, p2;
      frac_res_t r;
      bit [63:0] g;
      an = longint'(signed'(an_b));
      ad = longint'(signed'(ad_b));
      bn = longint'(signed'(bn_b));
      bd = longint'(signed'(bd_b));
      nu = 0;
      de = 0;
      r.st = ST_OK;
      if (ad == 0 || bd == 0) begin
        r.st = ST_ZERO_DEN;
      end else if (op == OP_DIV && bn == 0) begin
        r.st = ST_DIV_ZERO;
      end else begin
        case (op)
          OP_ADD, OP_SUB: begin
            p1 = an * bd;
            p2 = bn * ad;
            if (op == OP_SUB) p2 = -p2;
            if ((p2 > 0 && p1 > 64'sh7fffffffffffffff - p2) ||
                (p2 < 0 && p1 < 64'sh8000000000000000 - p2)) begin
              r.st = ST_OVERFLOW;
            end else begin
              nu = p1 + p2;
              de = ad * bd;
            end
          end
          OP_MUL: begin
            nu = an * bn;
            de = ad * bd;
          end
          default: begin
            nu = an * bd;
            de = ad * bn;
          end
        endcase
      end
      if (r.st == ST_OK) begin
        g = euclid(magn(nu), magn(de));
        r.num = div_by(nu, g);
        r.den = div_by(de, g);
      end else begin
        r.num = 0;
        r.den = 0;
      end
      op_cnt[op]++;
      st_cnt[r.st]++;
      pending_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch @%0t: %s", $time, what);
    endtask

    task check_result(bit [63:0] num, bit [63:0] den, bit [1:0] st);
      frac_res_t e;
      if (pending_q.size() == 0) begin
        report("result beat with nothing pending");
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (st != e.st) report($sformatf("status %0d, want %0d", st, e.st));
      if (num != e.num) report($sformatf("res_num %0d, want %0d", $signed(num), $signed(e.num)));
      if (den != e.den) report($sformatf("res_den %0d, want %0d", $signed(den), $signed(e.den)));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  frac_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  longint unsigned cycles = 0;

  rational_arith_reduce_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats pending", cycles, sb.pending_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser);
  end

  task automatic send_req(op_e op, bit [31:0] an, bit [31:0] ad, bit [31:0] bn,
                          bit [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {bd, bn, ad, an};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, an, ad, bn, bd);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic bit [31:0] rand_operand();
    bit [31:0] v;
    int nb;
    case ($urandom_range(9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = $urandom;
      3: v = 32'hffff_ffff;
      default: begin
        nb = $urandom_range(1, 20);
        v = $urandom & ((32'd1 << nb) - 1);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_random();
    bit [31:0] an, ad, bn, bd;
    an = rand_operand();
    ad = rand_operand();
    bn = rand_operand();
    bd = rand_operand();
    case ($urandom_range(29))
      0: ad = 0;
      1: bd = 0;
      2: bn = 0;
      3: an = 0;
      default: ;
    endcase
    if (ad == 0 && bd == 0 && $urandom_range(3) != 0) ad = 32'd1;
    send_req(op_e'($urandom_range(3)), an, ad, bn, bd);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_random();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every op, zero dens, div by zero, overflow, zero numerator, extremes
    send_req(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_req(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_req(OP_MUL, -32'sd6, 32'd4, 32'd2, -32'sd9);
    send_req(OP_DIV, 32'd3, 32'd5, -32'sd9, 32'd10);
    send_req(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_req(OP_DIV, 32'd1, 32'd1, 32'd0, 32'd0);
    send_req(OP_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
    send_req(OP_DIV, 32'd7, 32'd3, 32'd0, 32'd5);
    send_req(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_req(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_req(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_req(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_req(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_req(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_req(OP_MUL, 32'd0, -32'sd7, 32'd5, 32'd3);
    send_req(OP_ADD, 32'd0, 32'd4, 32'd0, -32'sd6);
    send_req(OP_DIV, 32'd0, 32'd1, -32'sd1, 32'd1);
    send_req(OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_req(OP_MUL, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
    send_req(OP_ADD, 32'd46368, 32'd75025, 32'd28657, 32'd46368);
    drain();

    random_phase(330, 0, 0);
    random_phase(330, 87, 0);
    drain();
    random_phase(330, 0, 87);
    random_phase(330, 16, 16);
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    random_phase(110, 0, 0);
    drain();

    recv_stall_pct = 0;
    repeat (7000) @(posedge clk_i);
    $display("covered %0d results: add %0d sub %0d mul %0d div %0d", sb.checked,
             sb.op_cnt[OP_ADD], sb.op_cnt[OP_SUB], sb.op_cnt[OP_MUL], sb.op_cnt[OP_DIV]);
    $display("status mix: ok %0d zero-den %0d div-zero %0d overflow %0d, under stalls",
             sb.st_cnt[ST_OK], sb.st_cnt[ST_ZERO_DEN], sb.st_cnt[ST_DIV_ZERO],
             sb.st_cnt[ST_OVERFLOW]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/rar_pkg.sv
src/rar_front.sv
src/rar_queue.sv
src/rar_back.sv
src/rational_arith_reduce_top.sv
tb/rational_arith_reduce_top_tb.sv
